[hdl/afns_pkg.sv]
// shared types and constants for the avcc filler unit stripper
// no dependencies

package afns_pkg;

    localparam int MAX_PREFIX_BYTES = 4;
    localparam int PC_W = $clog2(MAX_PREFIX_BYTES + 1);
    localparam int IDX_W = (MAX_PREFIX_BYTES > 1) ? $clog2(MAX_PREFIX_BYTES) : 1;
    localparam logic [2:0] MAX_PREFIX_LEN = 3'(MAX_PREFIX_BYTES);

    localparam logic [7:0] TYPE_MASK = 8'h1f;
    localparam logic [7:0] FILLER_TYPE = 8'd12;
    localparam logic [2:0] HEADER_BYTES = 3'd5;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] REG_FILTER_ENABLE = 2'd0;
    localparam logic [1:0] REG_CODEC_IS_H264 = 2'd1;
    localparam logic [1:0] REG_LENGTH_SIZE = 2'd2;

    typedef struct packed {
        logic       filter_enable;
        logic       codec_is_h264;
        logic [2:0] length_size;
    } cfg_t;

    typedef struct packed {
        logic [MAX_PREFIX_BYTES-1:0][7:0] held;
        logic [PC_W-1:0]                  held_count;
        logic                             held_keep;
        logic                             cur_en;
        logic [7:0]                       cur_byte;
        logic                             cur_keep;
        logic                             last;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

[hdl/afns_front.sv]
// front end: accepts message bytes, parses unit prefixes, decides keep flags
// depends on afns_pkg

module afns_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  afns_pkg::cfg_t      cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data,
    input  logic                first,
    input  logic                last,
    input  logic [23:0]         message_length,
    input  logic                q_full,
    output logic                push,
    output afns_pkg::entry_t    entry
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_PREFIX = 2'd1;
    localparam logic [1:0] PH_AWAIT  = 2'd2;
    localparam logic [1:0] PH_BODY   = 2'd3;

    logic [2:0]                  header_index_reg, header_index_next;
    logic                        pass_rest_reg, pass_rest_next;
    logic [1:0]                  phase_reg, phase_next;
    logic [afns_pkg::PC_W-1:0]   prefix_count_reg, prefix_count_next;
    logic [31:0]                 unit_length_reg, unit_length_next;
    logic [31:0]                 payload_left_reg, payload_left_next;
    logic                        dropping_reg, dropping_next;
    logic [23:0]                 payload_size_reg, payload_size_next;
    logic [afns_pkg::MAX_PREFIX_BYTES-1:0][7:0] held_reg;

    logic [2:0]                  ls_eff;
    logic                        accept;
    logic                        drop;
    logic                        pb_run;
    logic                        pb_old;
    logic [afns_pkg::PC_W-1:0]   pc_in;
    logic [afns_pkg::PC_W-1:0]   pc_n;
    logic [31:0]                 ul_in;
    logic [31:0]                 ul_n;
    logic [32:0]                 sum;
    logic                        held_wr;
    logic [afns_pkg::IDX_W-1:0]  wr_idx;
    logic [afns_pkg::PC_W-1:0]   n_cnt;
    logic                        k1;
    logic                        cur_en;
    logic                        k2;

    assign in_ready = !q_full;
    assign accept = in_valid && in_ready;

    always_comb
    begin
        if (cfg.length_size == 3'd0)
            ls_eff = 3'd1;
        else if (cfg.length_size > afns_pkg::MAX_PREFIX_LEN)
            ls_eff = afns_pkg::MAX_PREFIX_LEN;
        else
            ls_eff = cfg.length_size;
    end

    assign drop = (data & afns_pkg::TYPE_MASK) == afns_pkg::FILLER_TYPE;

    always_comb
    begin
        header_index_next = header_index_reg;
        pass_rest_next = pass_rest_reg;
        phase_next = phase_reg;
        prefix_count_next = prefix_count_reg;
        unit_length_next = unit_length_reg;
        payload_left_next = payload_left_reg;
        dropping_next = dropping_reg;
        payload_size_next = payload_size_reg;

        // a new message restarts the parser
        if (first)
        begin
            prefix_count_next = '0;
            phase_next = PH_HEADER;
            header_index_next = 3'd0;
            dropping_next = 1'b0;
            unit_length_next = 32'd0;
            payload_left_next = 32'd0;
            pass_rest_next = message_length < 24'(afns_pkg::HEADER_BYTES);
            payload_size_next = (message_length >= 24'(afns_pkg::HEADER_BYTES)) ?
                message_length - 24'(afns_pkg::HEADER_BYTES) : 24'd0;
        end
        if (!cfg.filter_enable || !cfg.codec_is_h264)
            pass_rest_next = 1'b1;

        n_cnt = '0;
        k1 = 1'b1;
        cur_en = 1'b0;
        k2 = 1'b1;
        pb_run = 1'b0;
        pb_old = 1'b0;
        pc_in = prefix_count_next;
        ul_in = unit_length_next;
        held_wr = 1'b0;
        wr_idx = pc_in[afns_pkg::IDX_W-1:0];

        if (pass_rest_next)
        begin
            n_cnt = prefix_count_next;
            cur_en = 1'b1;
            prefix_count_next = '0;
        end
        else
        begin
            unique case (phase_next)
                PH_HEADER:
                begin
                    cur_en = 1'b1;
                    if (header_index_next == 3'd1 && data == 8'd0)
                        pass_rest_next = 1'b1;
                    if (header_index_next < afns_pkg::HEADER_BYTES)
                        header_index_next = header_index_next + 3'd1;
                    if (header_index_next >= afns_pkg::HEADER_BYTES)
                    begin
                        phase_next = PH_PREFIX;
                        prefix_count_next = '0;
                        unit_length_next = 32'd0;
                    end
                end
                PH_PREFIX:
                begin
                    pb_run = 1'b1;
                    pb_old = 1'b1;
                end
                PH_AWAIT:
                begin
                    n_cnt = prefix_count_next;
                    k1 = !drop;
                    if (unit_length_next == 32'd0)
                    begin
                        // empty unit: this byte opens the next prefix
                        pc_in = '0;
                        ul_in = 32'd0;
                        pb_run = 1'b1;
                    end
                    else
                    begin
                        dropping_next = drop;
                        cur_en = 1'b1;
                        k2 = !drop;
                        payload_left_next = unit_length_next - 32'd1;
                        prefix_count_next = '0;
                        if (payload_left_next == 32'd0)
                        begin
                            phase_next = PH_PREFIX;
                            unit_length_next = 32'd0;
                        end
                        else
                            phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    cur_en = 1'b1;
                    k2 = !dropping_next;
                    if (payload_left_next != 32'd0)
                        payload_left_next = payload_left_next - 32'd1;
                    if (payload_left_next == 32'd0)
                    begin
                        phase_next = PH_PREFIX;
                        prefix_count_next = '0;
                        unit_length_next = 32'd0;
                    end
                end
                default:
                begin
                    cur_en = 1'b1;
                end
            endcase
        end

        // one prefix byte
        pc_n = pc_in + afns_pkg::PC_W'(1);
        ul_n = {ul_in[23:0], data};
        sum = {1'b0, ul_n} + 33'(ls_eff);
        if (pb_run)
        begin
            held_wr = 1'b1;
            wr_idx = pc_in[afns_pkg::IDX_W-1:0];
            phase_next = PH_PREFIX;
            prefix_count_next = pc_n;
            unit_length_next = ul_n;
            if (pc_n >= afns_pkg::PC_W'(ls_eff))
            begin
                if (sum >= {9'd0, payload_size_next})
                begin
                    // oversized unit: release prefix kept, pass the rest
                    pass_rest_next = 1'b1;
                    cur_en = 1'b1;
                    k2 = 1'b1;
                    if (pb_old)
                    begin
                        n_cnt = pc_in;
                        k1 = 1'b1;
                    end
                    prefix_count_next = '0;
                end
                else
                    phase_next = PH_AWAIT;
            end
        end

        if (last)
        begin
            // cut prefix released kept
            if (pb_run && prefix_count_next != '0)
            begin
                cur_en = 1'b1;
                k2 = 1'b1;
                if (pb_old)
                begin
                    n_cnt = pc_in;
                    k1 = 1'b1;
                end
            end
            prefix_count_next = '0;
            pass_rest_next = 1'b1;
            phase_next = PH_HEADER;
            header_index_next = 3'd0;
            dropping_next = 1'b0;
            unit_length_next = 32'd0;
            payload_left_next = 32'd0;
        end
    end

    assign push = accept && (n_cnt != '0 || cur_en);

    always_comb
    begin
        entry.held = held_reg;
        entry.held_count = n_cnt;
        entry.held_keep = k1;
        entry.cur_en = cur_en;
        entry.cur_byte = data;
        entry.cur_keep = k2;
        entry.last = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_index_reg <= 3'd0;
            pass_rest_reg <= 1'b0;
            phase_reg <= PH_HEADER;
            prefix_count_reg <= '0;
            unit_length_reg <= 32'd0;
            payload_left_reg <= 32'd0;
            dropping_reg <= 1'b0;
            payload_size_reg <= 24'd0;
        end
        else if (accept)
        begin
            header_index_reg <= header_index_next;
            pass_rest_reg <= pass_rest_next;
            phase_reg <= phase_next;
            prefix_count_reg <= prefix_count_next;
            unit_length_reg <= unit_length_next;
            payload_left_reg <= payload_left_next;
            dropping_reg <= dropping_next;
            payload_size_reg <= payload_size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && held_wr)
            held_reg[wr_idx] <= data;
    end

endmodule

[hdl/afns_queue.sv]
// short request queue between the parser and the output sequencer
// depends on afns_pkg

module afns_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  afns_pkg::entry_t   wr_entry,
    input  logic               pop,
    output afns_pkg::entry_t   rd_entry,
    output afns_pkg::qstat_t   stat
);

    afns_pkg::entry_t                mem_reg [afns_pkg::QUEUE_DEPTH];
    logic [afns_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [afns_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [afns_pkg::QUEUE_AW:0]     count_reg, count_next;

    assign rd_entry = mem_reg[rd_ptr_reg];
    assign stat.full = count_reg == (afns_pkg::QUEUE_AW + 1)'(afns_pkg::QUEUE_DEPTH);
    assign stat.empty = count_reg == '0;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + (afns_pkg::QUEUE_AW + 1)'(1);
        else if (pop && !push)
            count_next = count_reg - (afns_pkg::QUEUE_AW + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + afns_pkg::QUEUE_AW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + afns_pkg::QUEUE_AW'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

[hdl/afns_back.sv]
// back end: releases the bytes of each queued request, one per cycle while out_ready is high
// depends on afns_pkg

module afns_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  afns_pkg::entry_t   q_entry,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         byte_out,
    output logic               keep,
    output logic               message_end,
    output logic               run_last
);

    logic [afns_pkg::PC_W-1:0]   sel_reg;
    logic                        out_valid_reg;
    logic [7:0]                  byte_reg;
    logic                        keep_reg;
    logic                        message_end_reg;
    logic                        run_last_reg;

    logic                        load;
    logic                        sel_held;
    logic                        is_final;
    logic [7:0]                  sel_byte;
    logic                        sel_keep;

    assign load = !q_empty && (!out_valid_reg || out_ready);
    assign sel_held = sel_reg < q_entry.held_count;

    always_comb
    begin
        if (sel_held)
        begin
            sel_byte = q_entry.held[sel_reg[afns_pkg::IDX_W-1:0]];
            sel_keep = q_entry.held_keep;
            is_final = (sel_reg + afns_pkg::PC_W'(1) == q_entry.held_count) &&
                !q_entry.cur_en;
        end
        else
        begin
            sel_byte = q_entry.cur_byte;
            sel_keep = q_entry.cur_keep;
            is_final = 1'b1;
        end
    end

    assign pop = load && is_final;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                if (is_final)
                    sel_reg <= '0;
                else
                    sel_reg <= sel_reg + afns_pkg::PC_W'(1);
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= sel_byte;
            keep_reg <= sel_keep;
            message_end_reg <= is_final && q_entry.last;
            run_last_reg <= is_final;
        end
    end

    assign out_valid = out_valid_reg;
    assign byte_out = byte_reg;
    assign keep = keep_reg;
    assign message_end = message_end_reg;
    assign run_last = run_last_reg;

endmodule

[hdl/avcc_filler_nal_stripper_top.sv]
// top level of the avcc filler unit stripper: config registers and assembly
// depends on afns_pkg, afns_front, afns_queue, afns_back
//
// usage: message bytes enter on the in_valid/in_ready channel, one byte per
// request with first, last and message_length. each byte leaves on the
// out_valid/out_ready channel as byte_out with a keep flag (0 marks a byte of
// a filler unit); message_end flags the byte that came in with last, run_last
// the final output released by one input byte.
// an accepted byte that releases output is written to the request queue and then to the output register.
// throughput: one byte per cycle unless the queue is full; length prefix
// bytes are held and then released in a burst of up to five outputs, one per
// cycle from the output sequencer while out_ready is high, while a four-deep
// request queue keeps taking input; held bytes with no output take no queue slot.
// the apb port holds filter_enable, codec_is_h264 and length_size; write them
// only while the block is idle.
// reset clears the parser, the queue and the output register, sets
// filter_enable to 0, codec_is_h264 to 1 and length_size to 4.
// when the receiver stalls, the output holds, the queue fills and in_ready
// drops once four requests wait.

module avcc_filler_nal_stripper_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   data,
    input  logic         first,
    input  logic         last,
    input  logic [23:0]  message_length,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   byte_out,
    output logic         keep,
    output logic         message_end,
    output logic         run_last
);

    afns_pkg::cfg_t      cfg_reg;
    afns_pkg::entry_t    wr_entry;
    afns_pkg::entry_t    rd_entry;
    afns_pkg::qstat_t    q_stat;
    logic                push;
    logic                pop;
    logic                cfg_wr;
    logic [1:0]          reg_idx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_enable <= 1'b0;
            cfg_reg.codec_is_h264 <= 1'b1;
            cfg_reg.length_size <= 3'd4;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                afns_pkg::REG_FILTER_ENABLE: cfg_reg.filter_enable <= pwdata[0];
                afns_pkg::REG_CODEC_IS_H264: cfg_reg.codec_is_h264 <= pwdata[0];
                afns_pkg::REG_LENGTH_SIZE:   cfg_reg.length_size <= pwdata[2:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            afns_pkg::REG_FILTER_ENABLE: prdata = {31'd0, cfg_reg.filter_enable};
            afns_pkg::REG_CODEC_IS_H264: prdata = {31'd0, cfg_reg.codec_is_h264};
            afns_pkg::REG_LENGTH_SIZE:   prdata = {29'd0, cfg_reg.length_size};
            default:                     prdata = 32'd0;
        endcase
    end

    afns_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data           (data),
        .first          (first),
        .last           (last),
        .message_length (message_length),
        .q_full         (q_stat.full),
        .push           (push),
        .entry          (wr_entry)
    );

    afns_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (rd_entry),
        .stat     (q_stat)
    );

    afns_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_stat.empty),
        .q_entry     (rd_entry),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .byte_out    (byte_out),
        .keep        (keep),
        .message_end (message_end),
        .run_last    (run_last)
    );

    // a message end always closes a run
    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_end |-> run_last)
        else $error("message_end without run_last");

    // the final byte of a message always produces output
    a_last_queued: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last |=> !q_stat.empty)
        else $error("last byte produced no request");

    // a full queue means the output sequencer is presenting a result
    a_full_drains: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> out_valid)
        else $error("queue full while output idle");

endmodule

[tb/testbench.sv]
// testbench for avcc_filler_nal_stripper_top: directed and random byte streams,
// checked against a predictor of the filler unit stripper
// depends on afns_pkg and the rtl of the block
`timescale 1ns / 1ps

module testbench;

    typedef enum logic [1:0] {PH_HEADER, PH_PREFIX, PH_UNIT_HDR, PH_BODY} parse_phase_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       keep;
        logic       message_end;
        logic       run_last;
    } strip_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic [23:0] message_length;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  byte_out;
    logic        keep;
    logic        message_end;
    logic        run_last;

    avcc_filler_nal_stripper_top i_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data           (data),
        .first          (first),
        .last           (last),
        .message_length (message_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .byte_out       (byte_out),
        .keep           (keep),
        .message_end    (message_end),
        .run_last       (run_last)
    );

    // predictor copy of the block
    afns_pkg::cfg_t cfg = '{filter_enable: 1'b0, codec_is_h264: 1'b1, length_size: 3'd4};
    int            hdr_seen = 0;
    bit            rest_passes = 1'b0;
    parse_phase_t  parse_phase = PH_HEADER;
    int            held_cnt = 0;
    logic [31:0]   unit_len = '0;
    logic [31:0]   body_left = '0;
    bit            in_filler = 1'b0;
    logic [7:0]    held_bytes [afns_pkg::MAX_PREFIX_BYTES] = '{default: 8'h00};
    logic [23:0]   body_size = '0;

    strip_result_t step_out [$];
    strip_result_t expected_bytes [$];

    int          error_count = 0;
    int          tx_steady = 0;
    logic [7:0]  msg_buf [$];
    logic [23:0] msg_len_field;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(20_000_000);
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic int prefix_len(input logic [2:0] ls);
        if (ls < 3'd1)
            return 1;
        if (ls > afns_pkg::MAX_PREFIX_LEN)
            return afns_pkg::MAX_PREFIX_BYTES;
        return int'(ls);
    endfunction

    function automatic void emit_byte(input logic [7:0] b, input logic k);
        step_out.push_back('{byte_out: b, keep: k, message_end: 1'b0, run_last: 1'b0});
    endfunction

    function automatic void release_held(input logic k);
        for (int i = 0; i < held_cnt && i < afns_pkg::MAX_PREFIX_BYTES; i++)
            emit_byte(held_bytes[i], k);
        held_cnt = 0;
    endfunction

    function automatic void begin_prefix();
        parse_phase = PH_PREFIX;
        held_cnt = 0;
        unit_len = '0;
    endfunction

    function automatic void take_prefix_byte(input logic [7:0] b);
        int ls;
        ls = prefix_len(cfg.length_size);
        if (held_cnt < afns_pkg::MAX_PREFIX_BYTES)
            held_bytes[held_cnt] = b;
        held_cnt++;
        unit_len = {unit_len[23:0], b};
        if (held_cnt >= ls)
        begin
            if ({32'd0, unit_len} + 64'(ls) >= {40'd0, body_size})
            begin
                rest_passes = 1'b1;
                release_held(1'b1);
            end
            else
            begin
                parse_phase = PH_UNIT_HDR;
            end
        end
    endfunction

    function automatic void strip_predict(input logic [7:0] d, input logic f, input logic l,
                                          input logic [23:0] ml);
        logic drop;
        step_out.delete();
        if (f)
        begin
            held_cnt = 0;
            parse_phase = PH_HEADER;
            hdr_seen = 0;
            in_filler = 1'b0;
            unit_len = '0;
            body_left = '0;
            rest_passes = (ml < 24'(afns_pkg::HEADER_BYTES));
            body_size = (ml >= 24'(afns_pkg::HEADER_BYTES)) ?
                ml - 24'(afns_pkg::HEADER_BYTES) : 24'd0;
        end
        if (!cfg.filter_enable || !cfg.codec_is_h264)
            rest_passes = 1'b1;

        if (rest_passes)
        begin
            release_held(1'b1);
            emit_byte(d, 1'b1);
        end
        else
        begin
            case (parse_phase)
                PH_HEADER:
                begin
                    emit_byte(d, 1'b1);
                    if (hdr_seen == 1 && d == 8'h00)
                        rest_passes = 1'b1;
                    if (hdr_seen < int'(afns_pkg::HEADER_BYTES))
                        hdr_seen++;
                    if (hdr_seen >= int'(afns_pkg::HEADER_BYTES))
                        begin_prefix();
                end
                PH_PREFIX:
                begin
                    take_prefix_byte(d);
                end
                PH_UNIT_HDR:
                begin
                    drop = ((d & afns_pkg::TYPE_MASK) == afns_pkg::FILLER_TYPE);
                    if (unit_len == 32'd0)
                    begin
                        release_held(!drop);
                        begin_prefix();
                        take_prefix_byte(d);
                    end
                    else
                    begin
                        in_filler = drop;
                        release_held(!drop);
                        emit_byte(d, !drop);
                        body_left = unit_len - 32'd1;
                        if (body_left == 32'd0)
                            begin_prefix();
                        else
                            parse_phase = PH_BODY;
                    end
                end
                default:
                begin
                    emit_byte(d, !in_filler);
                    if (body_left > 32'd0)
                        body_left--;
                    if (body_left == 32'd0)
                        begin_prefix();
                end
            endcase
        end

        if (l)
        begin
            release_held(1'b1);
            rest_passes = 1'b1;
            parse_phase = PH_HEADER;
            hdr_seen = 0;
            in_filler = 1'b0;
            unit_len = '0;
            body_left = '0;
        end

        if (step_out.size() > 0)
        begin
            step_out[$].run_last = 1'b1;
            if (l)
                step_out[$].message_end = 1'b1;
        end
        foreach (step_out[i])
            expected_bytes.push_back(step_out[i]);
    endfunction

    function automatic logic [2:0] reg_value(input logic [1:0] idx);
        case (idx)
            afns_pkg::REG_FILTER_ENABLE: return {2'b00, cfg.filter_enable};
            afns_pkg::REG_CODEC_IS_H264: return {2'b00, cfg.codec_is_h264};
            default:                     return cfg.length_size;
        endcase
    endfunction

    // outputs checked and input requests predicted in one process
    always @(posedge clk)
    begin : check_results
        strip_result_t got;
        strip_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{byte_out: byte_out, keep: keep, message_end: message_end,
                        run_last: run_last};
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected output byte %02h keep %0b end %0b last %0b",
                                              got.byte_out, got.keep, got.message_end, got.run_last));
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf(
                            "byte %02h/%02h keep %0b/%0b end %0b/%0b run_last %0b/%0b (got/want)",
                            got.byte_out, want.byte_out, got.keep, want.keep,
                            got.message_end, want.message_end, got.run_last, want.run_last));
                end
            end
            if (in_valid && in_ready)
                strip_predict(data, first, last, message_length);
        end
    end

    initial
    begin : receiver
        int n;
        int r;
        logic rdy;
        out_ready = 1'b0;
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                rdy = 1'b1;
                n = $urandom_range(1, 12);
            end
            else if (r < 55)
            begin
                rdy = 1'b1;
                n = $urandom_range(100, 300);
            end
            else if (r < 92)
            begin
                rdy = 1'b0;
                n = $urandom_range(1, 3);
            end
            else
            begin
                rdy = 1'b0;
                n = $urandom_range(10, 40);
            end
            repeat (n)
            begin
                @(negedge clk);
                out_ready = rdy;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (tx_steady > 0)
        begin
            tx_steady--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            tx_steady = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic f, input logic l,
                             input logic [23:0] ml);
        int gap;
        gap = pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid = 1'b1;
        data = d;
        first = f;
        last = l;
        message_length = ml;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_message(input bit with_first, input bit with_last);
        int n;
        n = msg_buf.size();
        for (int i = 0; i < n; i++)
            send_byte(msg_buf[i], with_first && i == 0, with_last && i == n - 1,
                      (i == 0) ? msg_len_field : 24'($urandom));
    endtask

    // drain everything expected, then let held bytes settle
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic check_register(input logic [1:0] idx);
        logic [2:0] mask;
        mask = (idx == afns_pkg::REG_LENGTH_SIZE) ? 3'b111 : 3'b001;
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if ((prdata[2:0] & mask) !== reg_value(idx))
            report_mismatch($sformatf("register %0d reads %0h, want %0h",
                                      idx, prdata[2:0] & mask, reg_value(idx)));
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [2:0] val);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = ($urandom() & 32'hffff_fff8) | 32'(val);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            afns_pkg::REG_FILTER_ENABLE: cfg.filter_enable = pwdata[0];
            afns_pkg::REG_CODEC_IS_H264: cfg.codec_is_h264 = pwdata[0];
            default:                     cfg.length_size = pwdata[2:0];
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        check_register(idx);
    endtask

    task automatic append_prefix(input int ls, input logic [31:0] len);
        for (int i = ls - 1; i >= 0; i--)
            msg_buf.push_back(len[8*i +: 8]);
    endtask

    task automatic append_unit(input int ls, input int len);
        append_prefix(ls, 32'(len));
        if (len > 0)
        begin
            if ($urandom_range(0, 9) < 4)
                msg_buf.push_back({3'($urandom_range(0, 7)), afns_pkg::FILLER_TYPE[4:0]});
            else
                msg_buf.push_back(8'($urandom));
            repeat (len - 1) msg_buf.push_back(8'($urandom));
        end
    endtask

    task automatic build_message(input int ls);
        int ending;
        logic [31:0] big;
        msg_buf.delete();
        msg_buf.push_back(8'($urandom));
        msg_buf.push_back(($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
        repeat (3) msg_buf.push_back(8'($urandom));
        repeat ($urandom_range(0, 4))
            append_unit(ls, ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 9));
        ending = $urandom_range(0, 9);
        if (ending == 0)
        begin
            // oversized unit
            big = (ls == 4) ? $urandom() : ($urandom() & ((32'd1 << (8 * ls)) - 32'd1));
            append_prefix(ls, big);
            repeat ($urandom_range(0, 4)) msg_buf.push_back(8'($urandom));
        end
        else if (ending == 1)
        begin
            repeat ($urandom_range(1, ls)) msg_buf.push_back(8'($urandom));
        end
        else if (ending == 2 && msg_buf.size() > 5)
        begin
            repeat ($urandom_range(1, msg_buf.size() - 5)) void'(msg_buf.pop_back());
        end
        if ($urandom_range(0, 6) == 0)
            msg_len_field = ($urandom_range(0, 1) == 0) ? 24'($urandom_range(0, 6))
                                                         : 24'($urandom);
        else
            msg_len_field = 24'(msg_buf.size());
    endtask

    task automatic test_register_reset();
        check_register(afns_pkg::REG_FILTER_ENABLE);
        check_register(afns_pkg::REG_CODEC_IS_H264);
        check_register(afns_pkg::REG_LENGTH_SIZE);
    endtask

    // bytes before any first parse with an empty payload
    task automatic test_before_first_message();
        write_register(afns_pkg::REG_FILTER_ENABLE, 3'd1);
        msg_buf = '{8'h21, 8'h01, 8'h00, 8'h00, 8'h00, 8'h0c};
        send_message(1'b0, 1'b1);
        settle();
    endtask

    task automatic test_directed_messages();
        write_register(afns_pkg::REG_LENGTH_SIZE, 3'd1);
        // empty unit, then a filler unit
        msg_buf = '{8'hff, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h2c, 8'h00};
        msg_len_field = 24'd9;
        send_message(1'b1, 1'b1);
        // packet type zero passes whole message
        msg_buf = '{8'h17, 8'h00, 8'h00, 8'h00, 8'h00, 8'h0c};
        msg_len_field = 24'hffffff;
        send_message(1'b1, 1'b1);
        settle();
        write_register(afns_pkg::REG_LENGTH_SIZE, 3'd4);
        // prefix held, then restart by a short message
        msg_buf = '{8'hff, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        msg_len_field = 24'd200;
        send_message(1'b1, 1'b0);
        msg_buf = '{8'h07, 8'h01, 8'h03};
        msg_len_field = 24'd3;
        send_message(1'b1, 1'b1);
        settle();
    endtask

    task automatic run_random_phase(input logic fe, input logic codec, input logic [2:0] ls_val,
                                    input int n_bytes);
        int sent;
        int kind;
        int n;
        int ls;
        write_register(afns_pkg::REG_FILTER_ENABLE, {2'b00, fe});
        write_register(afns_pkg::REG_CODEC_IS_H264, {2'b00, codec});
        write_register(afns_pkg::REG_LENGTH_SIZE, ls_val);
        ls = prefix_len(ls_val);
        sent = 0;
        while (sent < n_bytes)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                    send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)), 24'($urandom));
                sent += n;
            end
            else
            begin
                build_message(ls);
                send_message(1'b1, kind != 1);
                sent += msg_buf.size();
            end
        end
        send_byte(8'($urandom), 1'b0, 1'b1, 24'($urandom));
        settle();
    endtask

    task automatic test_random_settings();
        run_random_phase(1'b1, 1'b1, 3'd4, 45);
        run_random_phase(1'b1, 1'b1, 3'd1, 45);
        run_random_phase(1'b1, 1'b1, 3'd2, 40);
        run_random_phase(1'b1, 1'b1, 3'd3, 40);
        run_random_phase(1'b1, 1'b1, 3'd0, 35);
        run_random_phase(1'b1, 1'b1, 3'd7, 35);
        run_random_phase(1'b1, 1'b1, 3'd5, 30);
        run_random_phase(1'b0, 1'b1, 3'd2, 30);
        run_random_phase(1'b1, 1'b0, 3'd3, 30);
        run_random_phase(1'b0, 1'b0, 3'd6, 20);
        run_random_phase(1'b1, 1'b1, 3'($urandom_range(1, 4)), 40);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        data = '0;
        first = 1'b0;
        last = 1'b0;
        message_length = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        test_register_reset();
        test_before_first_message();
        test_directed_messages();
        test_random_settings();

        settle();
        if (expected_bytes.size() != 0)
            report_mismatch($sformatf("%0d expected bytes never came out",
                                      expected_bytes.size()));
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
